>>> hw/rtl/vrn_pkg.sv
// Package for the velocity renormalizer: shared widths and pipeline geometry.
// No dependencies; used by vrn_sqrt, vrn_div and velocity_renormalize.
`default_nettype none
package vrn_pkg;
   localparam int FRAC_BITS_DEFAULT = 8;
   localparam int VEL_W   = 16;  // velocity component width
   localparam int SPD_W   = 15;  // target speed width
   localparam int SQ_W    = 32;  // sum of squares width
   localparam int ROOT_W  = 16;  // square root width
   localparam int PROD_W  = 32;  // component times speed
   localparam int MAG_W   = 31;  // magnitude of that product
   localparam int Q_W     = 16;  // quotient width
   localparam int SQRT_STAGES = SQ_W / 2;
   localparam int DIV_STAGES  = Q_W;
endpackage
`default_nettype wire

>>> hw/rtl/vrn_sqrt.sv
// Pipelined floor square root, one result digit per stage, with side payload.
// Depends on vrn_pkg.
`default_nettype none
module vrn_sqrt #(
   parameter int SIDE_W = 64
) (
   input  wire logic                                clock,
   input  wire logic [vrn_pkg::SQRT_STAGES-1:0]     en,
   input  wire logic [vrn_pkg::SQ_W-1:0]            sq,
   input  wire logic [SIDE_W-1:0]                   side_in,
   output logic      [vrn_pkg::ROOT_W-1:0]          root,
   output logic      [SIDE_W-1:0]                   side_out
);
   localparam int NS  = vrn_pkg::SQRT_STAGES;
   localparam int RW  = vrn_pkg::ROOT_W + 4;
   localparam int RTW = vrn_pkg::ROOT_W;
   localparam int VW  = vrn_pkg::SQ_W;

   logic [RW-1:0]     rem_ff  [NS];
   logic [RTW-1:0]    root_ff [NS];
   logic [VW-1:0]     val_ff  [NS];
   logic [SIDE_W-1:0] side_ff [NS];

   for (genvar k = 0; k < NS; k++) begin : g_stage
      logic [RW-1:0]     rem_prev;
      logic [RTW-1:0]    root_prev;
      logic [VW-1:0]     val_prev;
      logic [SIDE_W-1:0] side_prev;
      logic [RW-1:0]     part;
      logic [RW-1:0]     trial;
      logic [RW-1:0]     rem_in;
      logic [RTW-1:0]    root_in;

      if (k == 0) begin : g_first
         assign rem_prev  = '0;
         assign root_prev = '0;
         assign val_prev  = sq;
         assign side_prev = side_in;
      end else begin : g_next
         assign rem_prev  = rem_ff[k-1];
         assign root_prev = root_ff[k-1];
         assign val_prev  = val_ff[k-1];
         assign side_prev = side_ff[k-1];
      end

      always_comb begin
         part  = {rem_prev[RW-3:0], val_prev[VW-1 -: 2]};
         trial = RW'({root_prev, 2'b01});
         if (part >= trial) begin
            rem_in  = part - trial;
            root_in = {root_prev[RTW-2:0], 1'b1};
         end else begin
            rem_in  = part;
            root_in = {root_prev[RTW-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (en[k]) begin
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
            val_ff[k]  <= {val_prev[VW-3:0], 2'b00};
            side_ff[k] <= side_prev;
         end
      end
   end

   assign root     = root_ff[NS-1];
   assign side_out = side_ff[NS-1];
endmodule
`default_nettype wire

>>> hw/rtl/vrn_div.sv
// Pipelined restoring divider lane: magnitude divided by root, one quotient bit a stage.
// Depends on vrn_pkg.
`default_nettype none
module vrn_div (
   input  wire logic                              clock,
   input  wire logic [vrn_pkg::DIV_STAGES-1:0]    en,
   input  wire logic [vrn_pkg::MAG_W-1:0]         mag,
   input  wire logic                              sign_in,
   input  wire logic [vrn_pkg::ROOT_W-1:0]        root_in,
   output logic      [vrn_pkg::Q_W-1:0]           quot,
   output logic                                   sign_out,
   output logic      [vrn_pkg::ROOT_W-1:0]        root_out
);
   localparam int NS = vrn_pkg::DIV_STAGES;
   localparam int RT = vrn_pkg::ROOT_W;
   localparam int QW = vrn_pkg::Q_W;
   localparam int LW = vrn_pkg::Q_W;
   localparam int HW = vrn_pkg::MAG_W - LW;

   logic [RT-1:0] rem_ff  [NS];
   logic [LW-1:0] lo_ff   [NS];
   logic [QW-1:0] q_ff    [NS];
   logic [RT-1:0] d_ff    [NS];
   logic          sign_ff [NS];

   for (genvar k = 0; k < NS; k++) begin : g_stage
      logic [RT-1:0] rem_prev;
      logic [LW-1:0] lo_prev;
      logic [QW-1:0] q_prev;
      logic [RT-1:0] d_prev;
      logic          sign_prev;
      logic [RT:0]   part;
      logic [RT-1:0] rem_in;
      logic [QW-1:0] q_in;

      if (k == 0) begin : g_first
         assign rem_prev  = RT'(mag[vrn_pkg::MAG_W-1 -: HW]);
         assign lo_prev   = mag[LW-1:0];
         assign q_prev    = '0;
         assign d_prev    = root_in;
         assign sign_prev = sign_in;
      end else begin : g_next
         assign rem_prev  = rem_ff[k-1];
         assign lo_prev   = lo_ff[k-1];
         assign q_prev    = q_ff[k-1];
         assign d_prev    = d_ff[k-1];
         assign sign_prev = sign_ff[k-1];
      end

      always_comb begin
         part = {rem_prev, lo_prev[LW-1]};
         if (part >= {1'b0, d_prev}) begin
            rem_in = RT'(part - {1'b0, d_prev});
            q_in   = {q_prev[QW-2:0], 1'b1};
         end else begin
            rem_in = part[RT-1:0];
            q_in   = {q_prev[QW-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (en[k]) begin
            rem_ff[k]  <= rem_in;
            lo_ff[k]   <= {lo_prev[LW-2:0], 1'b0};
            q_ff[k]    <= q_in;
            d_ff[k]    <= d_prev;
            sign_ff[k] <= sign_prev;
         end
      end
   end

   assign quot     = q_ff[NS-1];
   assign sign_out = sign_ff[NS-1];
   assign root_out = d_ff[NS-1];
endmodule
`default_nettype wire

>>> hw/rtl/velocity_renormalize.sv
// Velocity renormalizer: scales a fixed-point 2D velocity to a target speed.
// 36 register stages from the accepting edge to rsp_valid;
// one request per cycle sustained while rsp_stall is low.
// The depth is set by the 16-stage square root and the 16-stage dividers, one bit a stage.
// Reset (synchronous, active high) clears only the stage valid bits.
// Depends on vrn_pkg, vrn_sqrt and vrn_div.
`default_nettype none
module velocity_renormalize #(
   parameter int FRAC_BITS = vrn_pkg::FRAC_BITS_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic signed [vrn_pkg::VEL_W-1:0]  req_vel_x_in,
   input  wire logic signed [vrn_pkg::VEL_W-1:0]  req_vel_y_in,
   input  wire logic        [vrn_pkg::SPD_W-1:0]  req_target_speed,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic signed      [vrn_pkg::VEL_W-1:0]  rsp_vel_x_out,
   output logic signed      [vrn_pkg::VEL_W-1:0]  rsp_vel_y_out
);
   localparam int VW  = vrn_pkg::VEL_W;
   localparam int PW  = vrn_pkg::PROD_W;
   localparam int MW  = vrn_pkg::MAG_W;
   localparam int SQS = vrn_pkg::SQRT_STAGES;
   localparam int DVS = vrn_pkg::DIV_STAGES;
   // stage map: 0 squares, 1 sum and products, sqrt, abs, div, final
   localparam int ST_SQRT = 2;
   localparam int ST_ABS  = ST_SQRT + SQS;
   localparam int ST_DIV  = ST_ABS + 1;
   localparam int ST_FIN  = ST_DIV + DVS;
   localparam int NS      = ST_FIN + 1;
   localparam logic signed [VW-1:0] FIX_ONE = VW'(1 << FRAC_BITS);

   // Per-stage valid bits; a stage loads whenever it is empty or its successor loads,
   // so bubbles collapse and a stalled result does not block upstream work.
   logic [NS-1:0] valid_ff;
   logic [NS-1:0] en;

   always_comb begin
      en[NS-1] = !valid_ff[NS-1] || !rsp_stall;
      for (int i = NS - 2; i >= 0; i--) begin
         en[i] = !valid_ff[i] || en[i+1];
      end
   end

   assign req_stall = !en[0];
   assign rsp_valid = valid_ff[NS-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (en[0]) begin
            valid_ff[0] <= req_valid;
         end
         for (int i = 1; i < NS; i++) begin
            if (en[i]) begin
               valid_ff[i] <= valid_ff[i-1];
            end
         end
      end
   end

   // Stage 0: substitute (one, minus one) for a zero vector, square the components.
   logic signed [VW-1:0]            x0_in, y0_in;
   logic signed [VW-1:0]            x0_ff, y0_ff;
   logic [vrn_pkg::SPD_W-1:0]       spd0_ff;
   logic [vrn_pkg::SQ_W-1:0]        xx0_ff, yy0_ff;
   logic signed [2*VW-1:0]          xx0_in, yy0_in;

   always_comb begin
      if (req_vel_x_in == '0 && req_vel_y_in == '0) begin
         x0_in = FIX_ONE;
         y0_in = -FIX_ONE;
      end else begin
         x0_in = req_vel_x_in;
         y0_in = req_vel_y_in;
      end
      xx0_in = x0_in * x0_in;
      yy0_in = y0_in * y0_in;
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         x0_ff   <= x0_in;
         y0_ff   <= y0_in;
         spd0_ff <= req_target_speed;
         xx0_ff  <= vrn_pkg::SQ_W'(xx0_in);
         yy0_ff  <= vrn_pkg::SQ_W'(yy0_in);
      end
   end

   // Stage 1: sum of squares, and each component times the speed.
   logic [vrn_pkg::SQ_W-1:0] sq1_ff;
   logic signed [PW-1:0]     px1_ff, py1_ff;
   logic signed [VW-1:0]     spd_s;

   assign spd_s = $signed({1'b0, spd0_ff});

   always_ff @(posedge clock) begin
      if (en[1]) begin
         sq1_ff <= xx0_ff + yy0_ff;
         px1_ff <= x0_ff * spd_s;
         py1_ff <= y0_ff * spd_s;
      end
   end

   // Square root, carrying both products alongside.
   logic [vrn_pkg::ROOT_W-1:0] root_sq;
   logic [2*PW-1:0]            side_sq;

   vrn_sqrt #(.SIDE_W(2 * PW)) u_sqrt (
      .clock    (clock),
      .en       (en[ST_SQRT +: SQS]),
      .sq       (sq1_ff),
      .side_in  ({px1_ff, py1_ff}),
      .root     (root_sq),
      .side_out (side_sq)
   );

   // Split the products into sign and magnitude for the dividers.
   logic signed [PW-1:0]       pxs, pys;
   logic [PW-1:0]              pxa, pya;
   logic [MW-1:0]              ax_ff, ay_ff;
   logic                       sx_ff, sy_ff;
   logic [vrn_pkg::ROOT_W-1:0] r_abs_ff;

   always_comb begin
      pxs = $signed(side_sq[2*PW-1:PW]);
      pys = $signed(side_sq[PW-1:0]);
      pxa = pxs[PW-1] ? PW'(-pxs) : PW'(pxs);
      pya = pys[PW-1] ? PW'(-pys) : PW'(pys);
   end

   always_ff @(posedge clock) begin
      if (en[ST_ABS]) begin
         ax_ff    <= pxa[MW-1:0];
         ay_ff    <= pya[MW-1:0];
         sx_ff    <= pxs[PW-1];
         sy_ff    <= pys[PW-1];
         r_abs_ff <= root_sq;
      end
   end

   // Two divider lanes in lockstep; the root travels in each.
   logic [vrn_pkg::Q_W-1:0]    qx, qy;
   logic                       sx_d, sy_d;
   logic [vrn_pkg::ROOT_W-1:0] r_dx, r_dy;

   vrn_div u_div_x (
      .clock    (clock),
      .en       (en[ST_DIV +: DVS]),
      .mag      (ax_ff),
      .sign_in  (sx_ff),
      .root_in  (r_abs_ff),
      .quot     (qx),
      .sign_out (sx_d),
      .root_out (r_dx)
   );

   vrn_div u_div_y (
      .clock    (clock),
      .en       (en[ST_DIV +: DVS]),
      .mag      (ay_ff),
      .sign_in  (sy_ff),
      .root_in  (r_abs_ff),
      .quot     (qy),
      .sign_out (sy_d),
      .root_out (r_dy)
   );

   // Final stage: restore signs; a zero root falls back to (one, minus one).
   logic signed [VW-1:0] x_fin_in, y_fin_in;
   logic signed [VW-1:0] x_fin_ff, y_fin_ff;

   always_comb begin
      x_fin_in = sx_d ? -$signed(qx) : $signed(qx);
      y_fin_in = sy_d ? -$signed(qy) : $signed(qy);
      if (r_dx == '0 || r_dy == '0) begin
         x_fin_in = FIX_ONE;
         y_fin_in = -FIX_ONE;
      end
   end

   always_ff @(posedge clock) begin
      if (en[ST_FIN]) begin
         x_fin_ff <= x_fin_in;
         y_fin_ff <= y_fin_in;
      end
   end

   assign rsp_vel_x_out = x_fin_ff;
   assign rsp_vel_y_out = y_fin_ff;
endmodule
`default_nettype wire
